// File: hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell of one chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_APPEND,
    CELL_TRIM
  } cell_op_t;

endpackage

// File: hw/rtl/dq_if.sv
// Handshake interfaces for the request and response channels of the queue.
interface dq_req_if
  import dq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_rsp_if
  import dq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  pop_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output pop_value, output status, output count, input ready);
  modport sink (input valid, input pop_value, input status, input count, output ready);
endinterface

// File: hw/rtl/dq_cell.sv
// One storage cell of a chain: a data word and an occupied flag.
module dq_cell
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_op_t              op,
  input  logic [DATA_WIDTH-1:0] load_value,
  input  logic                  prev_valid,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic                  next_valid,
  input  logic [DATA_WIDTH-1:0] next_data,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] data
);

  logic                  valid_next;
  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    case (op)
      CELL_INSERT: begin
        // Contents move one cell away from the head.
        valid_next = prev_valid;
        data_next  = prev_data;
      end
      CELL_REMOVE: begin
        // Contents move one cell toward the head.
        valid_next = next_valid;
        data_next  = next_data;
      end
      CELL_APPEND: begin
        // Only the first free cell takes the new word.
        if (!valid && prev_valid) begin
          valid_next = 1'b1;
          data_next  = load_value;
        end
      end
      CELL_TRIM: begin
        // Only the last occupied cell lets go.
        if (valid && !next_valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
        valid_next = valid;
        data_next  = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: hw/rtl/dq_chain.sv
// A row of cells that holds the queue packed against cell zero, the head.
module dq_chain
  import dq_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_op_t              op,
  input  logic [DATA_WIDTH-1:0] load_value,
  output logic                  head_valid,
  output logic [DATA_WIDTH-1:0] head_data,
  output logic                  tail_valid
);

  logic [DEPTH-1:0]      cell_valid;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_valid;
    logic [DATA_WIDTH-1:0] prev_data;
    logic                  next_valid;
    logic [DATA_WIDTH-1:0] next_data;

    // The head sees the incoming word as an always occupied neighbor.
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_data  = load_value;
    end else begin : g_inner_prev
      assign prev_valid = cell_valid[i-1];
      assign prev_data  = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner_next
      assign next_valid = cell_valid[i+1];
      assign next_data  = cell_data[i+1];
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .load_value(load_value),
      .prev_valid(prev_valid),
      .prev_data (prev_data),
      .next_valid(next_valid),
      .next_data (next_data),
      .valid     (cell_valid[i]),
      .data      (cell_data[i])
    );
  end

  assign head_valid = cell_valid[0];
  assign head_data  = cell_data[0];
  assign tail_valid = cell_valid[DEPTH-1];

endmodule

// File: hw/rtl/double_ended_queue.sv
// Top level of the fixed-capacity double-ended queue.
//
// Usage: each request transaction on req carries an opcode (push front, pop
// front, push back, pop back) and a data word that only pushes use. Every
// request produces exactly one response transaction on rsp with the popped
// word (zero unless a pop succeeded), a status (done, push refused because
// the queue is full, pop refused because it is empty) and the element count
// after the operation.
// The queue is kept twice, in two rows of DEPTH cells. In the front row the
// front element sits in cell zero; in the back row the back element does. An
// operation at one end shifts that end's row by one cell and appends to or
// trims the far end of the other row, so both popped words come from a cell
// zero and every cell only talks to its two neighbors.
// Throughput is one transaction per cycle for every opcode while the skid
// register is empty; the row shift and the occupancy counter update finish
// in the cycle of acceptance, and the response is registered.
// A two-entry output buffer sits on the response side: when the receiver
// stalls, one further request is still accepted and its response waits in
// the skid register; req.ready drops only while that register is full.
// Reset empties the queue and clears the output buffer; stored words are not
// cleared, since no pop can reach a cell that was not written.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  dq_req_if.sink       req,
  dq_rsp_if.source     rsp
);

  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int EXT_W     = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CNT_EXT_W = OCC_W + COUNT_W;

  // Handshake strobes.
  logic accept;
  logic drain;

  // Operation decode.
  opcode_t               op;
  logic                  is_push;
  logic                  full;
  logic                  empty;
  status_t               op_status;
  cell_op_t              front_op;
  cell_op_t              back_op;
  logic [DATA_WIDTH-1:0] store_value;

  // Chain outputs.
  logic                  front_head_valid;
  logic [DATA_WIDTH-1:0] front_head_data;
  logic                  front_tail_valid;
  logic                  back_head_valid;
  logic [DATA_WIDTH-1:0] back_head_data;
  logic                  back_tail_valid;

  // Occupancy.
  logic [OCC_W-1:0]     occupancy;
  logic [OCC_W-1:0]     occupancy_next;

  // Result of the operation being accepted.
  logic [DATA_WIDTH-1:0] popped_word;
  logic [EXT_W-1:0]      popped_ext;
  logic [VALUE_W-1:0]    result_pop_value;
  logic [CNT_EXT_W-1:0]  count_ext;
  logic [COUNT_W-1:0]    result_count;

  // Output register and skid register.
  logic                main_valid;
  logic [VALUE_W-1:0]  main_pop_value;
  status_t             main_status;
  logic [COUNT_W-1:0]  main_count;
  logic                skid_valid;
  logic [VALUE_W-1:0]  skid_pop_value;
  status_t             skid_status;
  logic [COUNT_W-1:0]  skid_count;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign drain     = rsp.valid && rsp.ready;

  assign op          = opcode_t'(req.opcode);
  assign is_push     = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign full        = front_tail_valid;
  assign empty       = !front_head_valid;
  assign store_value = DATA_WIDTH'(req.push_value);

  // Status, row commands and popped word for the request on the port.
  always_comb begin
    op_status   = ST_DONE;
    front_op    = CELL_HOLD;
    back_op     = CELL_HOLD;
    popped_word = '0;
    if (is_push && full) begin
      op_status = ST_FULL;
    end else if (!is_push && empty) begin
      op_status = ST_EMPTY;
    end else begin
      case (op)
        OP_PUSH_FRONT: begin
          front_op = CELL_INSERT;
          back_op  = CELL_APPEND;
        end
        OP_POP_FRONT: begin
          front_op    = CELL_REMOVE;
          back_op     = CELL_TRIM;
          popped_word = front_head_data;
        end
        OP_PUSH_BACK: begin
          front_op = CELL_APPEND;
          back_op  = CELL_INSERT;
        end
        OP_POP_BACK: begin
          front_op    = CELL_TRIM;
          back_op     = CELL_REMOVE;
          popped_word = back_head_data;
        end
        default: begin
          front_op = CELL_HOLD;
          back_op  = CELL_HOLD;
        end
      endcase
    end
    // The rows only move when the request is actually taken.
    if (!accept) begin
      front_op = CELL_HOLD;
      back_op  = CELL_HOLD;
    end
  end

  always_comb begin
    occupancy_next = occupancy;
    if (op_status == ST_DONE) begin
      if (is_push) begin
        occupancy_next = occupancy + OCC_W'(1);
      end else begin
        occupancy_next = occupancy - OCC_W'(1);
      end
    end
  end

  assign popped_ext       = EXT_W'(popped_word);
  assign result_pop_value = popped_ext[VALUE_W-1:0];
  assign count_ext        = CNT_EXT_W'(occupancy_next);
  assign result_count     = count_ext[COUNT_W-1:0];

  dq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front_chain (
    .clk       (clk),
    .rst       (rst),
    .op        (front_op),
    .load_value(store_value),
    .head_valid(front_head_valid),
    .head_data (front_head_data),
    .tail_valid(front_tail_valid)
  );

  dq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back_chain (
    .clk       (clk),
    .rst       (rst),
    .op        (back_op),
    .load_value(store_value),
    .head_valid(back_head_valid),
    .head_data (back_head_data),
    .tail_valid(back_tail_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= occupancy_next;
    end
  end

  // Output buffer control. A new result goes to the output register when it
  // is empty or being drained, and to the skid register otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (drain) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= accept;
        end
      end else if (accept) begin
        if (main_valid) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain && skid_valid) begin
      main_pop_value <= skid_pop_value;
      main_status    <= skid_status;
      main_count     <= skid_count;
    end else if (accept && (drain || !main_valid)) begin
      main_pop_value <= result_pop_value;
      main_status    <= op_status;
      main_count     <= result_count;
    end
    if (accept && main_valid && !drain) begin
      skid_pop_value <= result_pop_value;
      skid_status    <= op_status;
      skid_count     <= result_count;
    end
  end

  assign rsp.valid     = main_valid;
  assign rsp.pop_value = main_pop_value;
  assign rsp.status    = main_status;
  assign rsp.count     = main_count;

  // Both rows must always agree on whether the queue is empty or full.
  a_rows_agree_empty: assert property (@(posedge clk) disable iff (rst)
    front_head_valid == back_head_valid)
    else $error("front and back rows disagree on emptiness");

  a_rows_agree_full: assert property (@(posedge clk) disable iff (rst)
    front_tail_valid == back_tail_valid)
    else $error("front and back rows disagree on fullness");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    empty == (occupancy == '0))
    else $error("empty row does not match occupancy");

  a_full_matches_count: assert property (@(posedge clk) disable iff (rst)
    full == (occupancy == OCC_W'(DEPTH)))
    else $error("full row does not match occupancy");

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid register holds a result ahead of the output register");

endmodule
